>>> src/rlft_pkg.sv
// rlft_pkg: shared constants, types and codes of the rgb led frame transmitter
`timescale 1ns / 1ps

package rlft_pkg;

   // matrix geometry
   localparam int MATRIX_WIDTH  = 8;
   localparam int MATRIX_HEIGHT = 8;
   localparam int LED_COUNT     = MATRIX_WIDTH * MATRIX_HEIGHT;
   localparam int LED_IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int LED_CNT_W     = $clog2(LED_COUNT + 1);
   localparam int BYTES_PER_LED = 3;

   // field widths
   localparam int CMD_W   = 2;
   localparam int COORD_W = 4;
   localparam int CHAN_W  = 8;
   localparam int COLOR_W = 3 * CHAN_W;
   localparam int TICK_W  = 8;
   localparam int LATCH_W = 13;
   localparam int LEDS_W  = 7;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] REG_ONE_HIGH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_LOW    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_HIGH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_LOW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LATCH      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LEDS       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SERPENTINE = 3'd6;

   localparam logic [TICK_W-1:0]  ONE_HIGH_RST   = 8'd9;
   localparam logic [TICK_W-1:0]  ONE_LOW_RST    = 8'd11;
   localparam logic [TICK_W-1:0]  ZERO_HIGH_RST  = 8'd4;
   localparam logic [TICK_W-1:0]  ZERO_LOW_RST   = 8'd16;
   localparam logic [LATCH_W-1:0] LATCH_RST      = 13'd4800;
   localparam logic [LEDS_W-1:0]  LEDS_RST       = 7'd64;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_PIXEL = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_SHOW  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HIGH,
      PH_LOW,
      PH_LATCH
   } phase_type;

   typedef struct packed {
      logic [TICK_W-1:0]  one_high_ticks;
      logic [TICK_W-1:0]  one_low_ticks;
      logic [TICK_W-1:0]  zero_high_ticks;
      logic [TICK_W-1:0]  zero_low_ticks;
      logic [LATCH_W-1:0] latch_ticks;
      logic [LEDS_W-1:0]  leds_to_send;
      logic               serpentine_order;
   } cfg_type;

   // classified command as it travels through the queue
   typedef struct packed {
      cmd_type                cmd;
      logic                   bad_pixel;
      logic [LED_IDX_W-1:0]   led_idx;
      logic [COLOR_W-1:0]     color;     // green, red, blue from msb down
   } item_type;

endpackage

>>> src/rlft_if.sv
// rlft_if: valid/ready channel interfaces for command, response and csr transfers
`timescale 1ns / 1ps

interface rlft_req_if import rlft_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [COORD_W-1:0] col;
   logic [COORD_W-1:0] row;
   logic [CHAN_W-1:0]  red;
   logic [CHAN_W-1:0]  green;
   logic [CHAN_W-1:0]  blue;

   modport source (output valid, cmd, col, row, red, green, blue, input ready);
   modport sink   (input valid, cmd, col, row, red, green, blue, output ready);
endinterface

interface rlft_rsp_if;
   logic valid;
   logic ready;
   logic line_level;
   logic busy_res;
   logic rejected;
   logic frame_done;

   modport source (output valid, line_level, busy_res, rejected, frame_done, input ready);
   modport sink   (input valid, line_level, busy_res, rejected, frame_done, output ready);
endinterface

interface rlft_csr_if import rlft_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> src/rlft_ram.sv
// rlft_ram: generic single write port ram with registered read
`timescale 1ns / 1ps

module rlft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> src/rlft_front.sv
// rlft_front: accepts command transfers, range checks and maps pixel coordinates
`timescale 1ns / 1ps

module rlft_front import rlft_pkg::*; (
   rlft_req_if.sink      req_chan,
   input  logic          serpentine_order,
   input  logic          q_ready,
   output logic          q_push,
   output item_type      q_item
);

   int col_i;
   int row_i;
   int x_i;

   assign req_chan.ready = q_ready;
   assign q_push         = req_chan.valid && q_ready;

   always_comb begin
      col_i = int'(req_chan.col);
      row_i = int'(req_chan.row);
      // serpentine wiring runs odd rows right to left
      if (serpentine_order && req_chan.row[0]) begin
         x_i = MATRIX_WIDTH - 1 - col_i;
      end else begin
         x_i = col_i;
      end
      q_item.cmd       = cmd_type'(req_chan.cmd);
      q_item.bad_pixel = (col_i >= MATRIX_WIDTH) || (row_i >= MATRIX_HEIGHT);
      q_item.led_idx   = LED_IDX_W'(row_i * MATRIX_WIDTH + x_i);
      q_item.color     = {req_chan.green, req_chan.red, req_chan.blue};
   end

endmodule

>>> src/rlft_queue.sv
// rlft_queue: short fifo of classified commands between front and back
`timescale 1ns / 1ps

module rlft_queue import rlft_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     ready,
   input  logic     pop,
   output item_type pop_item,
   output logic     valid
);

   item_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign ready    = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> src/rlft_back.sv
// rlft_back: frame store, waveform sequencer and response register
`timescale 1ns / 1ps

module rlft_back import rlft_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_valid,
   input  item_type   q_item,
   output logic       q_pop,
   rlft_rsp_if.source rsp_chan
);

   phase_type              phase_ff, phase_in;
   logic [LATCH_W-1:0]     cnt_ff, cnt_in;
   logic [LED_IDX_W-1:0]   led_ptr_ff, led_ptr_in;
   logic [1:0]             byte_sel_ff, byte_sel_in;
   logic [2:0]             bit_ptr_ff, bit_ptr_in;
   logic [LED_CNT_W-1:0]   n_leds_ff, n_leds_in;
   logic [LED_COUNT-1:0]   valid_ff, valid_in;
   logic                   rd_valid_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   line_ff, line_in;
   logic                   busy_ff, busy_in;
   logic                   rej_ff, rej_in;
   logic                   done_ff, done_in;

   logic                   exec;
   logic                   ram_we;
   logic [COLOR_W-1:0]     rd_data;
   logic [COLOR_W-1:0]     word;
   logic [CHAN_W-1:0]      cur_byte;
   logic                   cur_bit;
   logic [LATCH_W-1:0]     limit;
   logic [LED_CNT_W-1:0]   n_sat;

   function automatic logic [LATCH_W-1:0] len_m1(input logic [LATCH_W-1:0] v);
      return (v == '0) ? '0 : v - 1'b1;
   endfunction

   rlft_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (LED_COUNT)
   ) u_store (
      .clock   (clock),
      .we      (ram_we),
      .wr_addr (q_item.led_idx),
      .wr_data (q_item.color),
      .rd_addr (led_ptr_in),
      .rd_data (rd_data)
   );

   assign exec  = q_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign q_pop = exec;

   // unwritten entries read as zero
   assign word = rd_valid_ff ? rd_data : '0;

   always_comb begin
      case (byte_sel_ff)
         2'd0:    cur_byte = word[COLOR_W-1 -: CHAN_W];
         2'd1:    cur_byte = word[COLOR_W-CHAN_W-1 -: CHAN_W];
         default: cur_byte = word[CHAN_W-1:0];
      endcase
      cur_bit = cur_byte[~bit_ptr_ff];
   end

   always_comb begin
      case (phase_ff)
         PH_HIGH: limit = len_m1(LATCH_W'(cur_bit ? cfg.one_high_ticks : cfg.zero_high_ticks));
         PH_LOW:  limit = len_m1(LATCH_W'(cur_bit ? cfg.one_low_ticks : cfg.zero_low_ticks));
         default: limit = len_m1(cfg.latch_ticks);
      endcase
      n_sat = (int'(cfg.leds_to_send) > LED_COUNT) ? LED_CNT_W'(LED_COUNT)
                                                   : LED_CNT_W'(cfg.leds_to_send);
   end

   always_comb begin
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      led_ptr_in   = led_ptr_ff;
      byte_sel_in  = byte_sel_ff;
      bit_ptr_in   = bit_ptr_ff;
      n_leds_in    = n_leds_ff;
      valid_in     = valid_ff;
      ram_we       = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      line_in      = line_ff;
      busy_in      = busy_ff;
      rej_in       = 1'b0;
      done_in      = 1'b0;

      if (exec) begin
         case (q_item.cmd)
            CMD_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  if (cnt_ff != limit) begin
                     cnt_in = cnt_ff + 1'b1;
                  end else begin
                     cnt_in = '0;
                     case (phase_ff)
                        PH_HIGH: phase_in = PH_LOW;
                        PH_LOW: begin
                           if (bit_ptr_ff == 3'd7) begin
                              bit_ptr_in = '0;
                              if (byte_sel_ff != 2'(BYTES_PER_LED - 1)) begin
                                 byte_sel_in = byte_sel_ff + 1'b1;
                                 phase_in    = PH_HIGH;
                              end else if (int'(led_ptr_ff) + 1 >= int'(n_leds_ff)) begin
                                 phase_in = PH_LATCH;
                              end else begin
                                 byte_sel_in = '0;
                                 led_ptr_in  = led_ptr_ff + 1'b1;
                                 phase_in    = PH_HIGH;
                              end
                           end else begin
                              bit_ptr_in = bit_ptr_ff + 1'b1;
                              phase_in   = PH_HIGH;
                           end
                        end
                        default: begin
                           phase_in = PH_IDLE;
                           done_in  = 1'b1;
                        end
                     endcase
                  end
               end
            end
            default: begin
               if (phase_ff != PH_IDLE) begin
                  rej_in = 1'b1;
               end else begin
                  case (q_item.cmd)
                     CMD_PIXEL: begin
                        if (q_item.bad_pixel) begin
                           rej_in = 1'b1;
                        end else begin
                           ram_we                   = 1'b1;
                           valid_in[q_item.led_idx] = 1'b1;
                        end
                     end
                     CMD_CLEAR: valid_in = '0;
                     default: begin
                        n_leds_in   = n_sat;
                        led_ptr_in  = '0;
                        byte_sel_in = '0;
                        bit_ptr_in  = '0;
                        cnt_in      = '0;
                        phase_in    = (n_sat == '0) ? PH_LATCH : PH_HIGH;
                     end
                  endcase
               end
            end
         endcase
         rsp_valid_in = 1'b1;
         line_in      = (phase_in == PH_HIGH);
         busy_in      = (phase_in != PH_IDLE);
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (!exec) begin
         rej_in  = rej_ff;
         done_in = done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         led_ptr_ff   <= '0;
         byte_sel_ff  <= '0;
         bit_ptr_ff   <= '0;
         n_leds_ff    <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         led_ptr_ff   <= led_ptr_in;
         byte_sel_ff  <= byte_sel_in;
         bit_ptr_ff   <= bit_ptr_in;
         n_leds_ff    <= n_leds_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[led_ptr_in];
      line_ff     <= line_in;
      busy_ff     <= busy_in;
      rej_ff      <= rej_in;
      done_ff     <= done_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.line_level = line_ff;
   assign rsp_chan.busy_res   = busy_ff;
   assign rsp_chan.rejected   = rej_ff;
   assign rsp_chan.frame_done = done_ff;

   a_idle_count_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> cnt_ff == '0)
      else $error("phase counter not cleared in idle");

   a_busy_reject: assert property (@(posedge clock) disable iff (reset)
      exec && q_item.cmd != CMD_TICK && phase_ff != PH_IDLE |=> rsp_valid_ff && rej_ff)
      else $error("command during frame not rejected");

   a_done_from_latch: assert property (@(posedge clock) disable iff (reset)
      exec && phase_ff != PH_LATCH |=> !done_ff)
      else $error("frame done outside latch period");

   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> phase_ff == PH_IDLE)
      else $error("store written during frame");

   a_led_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HIGH || phase_ff == PH_LOW) |-> int'(led_ptr_ff) < int'(n_leds_ff))
      else $error("led pointer beyond frame length");

endmodule

>>> src/rgb_led_frame_transmitter.sv
// rgb_led_frame_transmitter: top level with csr registers, front, queue and back
`timescale 1ns / 1ps
//
// usage
// - req_chan carries one command per transfer: tick, pixel write, clear or show
// - rsp_chan returns exactly one response per command, in order: line level,
//   busy flag, rejected flag and frame done flag
// - csr_chan writes the timing, led count and mapping registers; it is always
//   ready and should only be written while no command is in flight
// - throughput is one command per clock while rsp_chan takes the responses; ticks
//   sent every clock give pulse widths exact in clock cycles
// - a command accepted into the queue is executed by the back end from the queue
//   head and shows on rsp_chan from the back end's response register
// - the back end takes one command per cycle while rsp_chan accepts its response;
//   a response register parts it from rsp_chan
// - reset loads the default timing registers and marks every frame store
//   entry as unwritten, so the whole store reads zero at once, no clearing pass
// - when rsp_chan stalls the response is held, the two entry queue absorbs
//   the next commands and then req_chan ready drops
//
module rgb_led_frame_transmitter import rlft_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   rlft_req_if.sink    req_chan,
   rlft_rsp_if.source  rsp_chan,
   rlft_csr_if.sink    csr_chan
);

   cfg_type  cfg_ff, cfg_in;

   // queue hookup
   logic     q_push;
   logic     q_ready;
   item_type q_push_item;
   logic     q_pop;
   logic     q_valid;
   item_type q_pop_item;

   // csr writes are always accepted
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_ONE_HIGH:   cfg_in.one_high_ticks   = csr_chan.data[TICK_W-1:0];
            REG_ONE_LOW:    cfg_in.one_low_ticks    = csr_chan.data[TICK_W-1:0];
            REG_ZERO_HIGH:  cfg_in.zero_high_ticks  = csr_chan.data[TICK_W-1:0];
            REG_ZERO_LOW:   cfg_in.zero_low_ticks   = csr_chan.data[TICK_W-1:0];
            REG_LATCH:      cfg_in.latch_ticks      = csr_chan.data[LATCH_W-1:0];
            REG_LEDS:       cfg_in.leds_to_send     = csr_chan.data[LEDS_W-1:0];
            REG_SERPENTINE: cfg_in.serpentine_order = csr_chan.data[0];
            default:        cfg_in = cfg_ff;   // unused index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_high_ticks   <= ONE_HIGH_RST;
         cfg_ff.one_low_ticks    <= ONE_LOW_RST;
         cfg_ff.zero_high_ticks  <= ZERO_HIGH_RST;
         cfg_ff.zero_low_ticks   <= ZERO_LOW_RST;
         cfg_ff.latch_ticks      <= LATCH_RST;
         cfg_ff.leds_to_send     <= LEDS_RST;
         cfg_ff.serpentine_order <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: decode and pixel mapping
   rlft_front u_front (
      .req_chan         (req_chan),
      .serpentine_order (cfg_ff.serpentine_order),
      .q_ready          (q_ready),
      .q_push           (q_push),
      .q_item           (q_push_item)
   );

   // decouples command intake from execution
   rlft_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .ready     (q_ready),
      .pop       (q_pop),
      .pop_item  (q_pop_item),
      .valid     (q_valid)
   );

   // back: frame store and one-wire waveform
   rlft_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_valid),
      .q_item   (q_pop_item),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> sim/rgb_led_frame_transmitter_tb.sv
// rgb_led_frame_transmitter_tb: self-checking bench, directed table, random frames, then a wide pulse frame
`timescale 1ns / 1ps

module rgb_led_frame_transmitter_tb;
   import rlft_pkg::*;

   localparam int STORE_BYTES   = LED_COUNT * BYTES_PER_LED;
   localparam int RANDOM_ITEMS  = 900;   // item count at which the small random phases stop
   localparam int STALL_LIMIT   = 2000;  // cycles with no transfer on any channel
   localparam int BASE_IDLE_PCT = 29;

   // one response: {line_level, busy_res, rejected, frame_done}
   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic rejected;
      logic frame_done;
   } line_rsp_type;

   localparam line_rsp_type RSP_IDLE        = 4'b0000;
   localparam line_rsp_type RSP_REJECT_IDLE = 4'b0010;
   localparam line_rsp_type RSP_REJECT_BUSY = 4'b0110;
   localparam line_rsp_type RSP_LATCH       = 4'b0100;
   localparam line_rsp_type RSP_DONE        = 4'b0001;

   typedef struct packed {
      cmd_type            cmd;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
   } led_cmd_type;

   // one row of the directed table: either a register write or a command
   typedef struct {
      bit                    is_csr;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      led_cmd_type           item;
      bit                    typed;   // response written in by hand
      line_rsp_type          rsp;
   } dir_row_type;

   logic clock;
   logic reset;

   rlft_req_if req_if ();
   rlft_rsp_if rsp_if ();
   rlft_csr_if csr_if ();

   rgb_led_frame_transmitter uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // shadow of the transmitter: registers, frame store, waveform state
   // ---------------------------------------------------------------
   cfg_type            regs_shadow;
   logic [CHAN_W-1:0]  pix_mem [STORE_BYTES];
   int unsigned        byte_ptr;
   int unsigned        byte_total;
   logic [2:0]         bit_ptr;
   logic [7:0]         shift_reg;
   phase_type          wave;
   logic [LATCH_W-1:0] ph_count;

   line_rsp_type line_rsp_fifo [$];   // responses still owed by the block, oldest first
   dir_row_type  dir_rows [$];

   int fail_count  = 0;
   int n_sent      = 0;
   int idle_pct    = BASE_IDLE_PCT;
   int quiet_cycles = 0;
   bit csr_open    = 1'b0;          // csr valid left high after the last write

   // a phase length of zero behaves as one
   function automatic logic [LATCH_W-1:0] less_one(logic [LATCH_W-1:0] v);
      return (v == '0) ? '0 : v - 1'b1;
   endfunction

   function automatic void enter_bit_high();
      wave     = PH_HIGH;
      ph_count = less_one(LATCH_W'(shift_reg[7] ? regs_shadow.one_high_ticks
                                                : regs_shadow.zero_high_ticks));
   endfunction

   function automatic void enter_bit_low();
      wave     = PH_LOW;
      ph_count = less_one(LATCH_W'(shift_reg[7] ? regs_shadow.one_low_ticks
                                                : regs_shadow.zero_low_ticks));
   endfunction

   function automatic void enter_latch();
      wave     = PH_LATCH;
      ph_count = less_one(regs_shadow.latch_ticks);
   endfunction

   function automatic void load_byte();
      shift_reg = pix_mem[byte_ptr];
      bit_ptr   = '0;
   endfunction

   function automatic void reset_led_model();
      regs_shadow = '{ONE_HIGH_RST, ONE_LOW_RST, ZERO_HIGH_RST, ZERO_LOW_RST,
                      LATCH_RST, LEDS_RST, 1'b0};
      foreach (pix_mem[i]) pix_mem[i] = '0;
      byte_ptr   = 0;
      byte_total = 0;
      bit_ptr    = '0;
      shift_reg  = '0;
      wave       = PH_IDLE;
      ph_count   = '0;
   endfunction

   // one tick of the waveform, returns 1 when the latch period just ended
   function automatic bit step_waveform();
      if (wave == PH_IDLE) return 1'b0;
      if (ph_count != '0) begin
         ph_count = ph_count - 1'b1;
         return 1'b0;
      end
      case (wave)
         PH_HIGH: enter_bit_low();
         PH_LOW: begin
            if (bit_ptr == 3'd7) begin
               byte_ptr++;
               if (byte_ptr >= byte_total) begin
                  enter_latch();
               end else begin
                  load_byte();
                  enter_bit_high();
               end
            end else begin
               bit_ptr   = bit_ptr + 1'b1;
               shift_reg = shift_reg << 1;
               enter_bit_high();
            end
         end
         default: begin
            wave     = PH_IDLE;
            ph_count = '0;
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   // applies one command to the shadow and returns the line response it causes
   function automatic line_rsp_type run_led_command(led_cmd_type c);
      line_rsp_type r;
      int unsigned  x;
      int unsigned  base;
      int unsigned  n;
      r = RSP_IDLE;
      if (c.cmd == CMD_TICK) begin
         r.frame_done = step_waveform();
      end else if (wave != PH_IDLE) begin
         r.rejected = 1'b1;
      end else begin
         case (c.cmd)
            CMD_PIXEL: begin
               if (c.col >= MATRIX_WIDTH || c.row >= MATRIX_HEIGHT) begin
                  r.rejected = 1'b1;
               end else begin
                  // serpentine wiring runs odd rows right to left
                  x = (regs_shadow.serpentine_order && c.row[0]) ?
                      MATRIX_WIDTH - 1 - c.col : c.col;
                  base = (c.row * MATRIX_WIDTH + x) * BYTES_PER_LED;
                  pix_mem[base]     = c.green;
                  pix_mem[base + 1] = c.red;
                  pix_mem[base + 2] = c.blue;
               end
            end
            CMD_CLEAR: foreach (pix_mem[i]) pix_mem[i] = '0;
            default: begin
               n = 32'(regs_shadow.leds_to_send);
               if (n > LED_COUNT) n = LED_COUNT;
               byte_total = n * BYTES_PER_LED;
               byte_ptr   = 0;
               if (byte_total == 0) begin
                  // nothing to stream, straight into the latch
                  bit_ptr   = '0;
                  shift_reg = '0;
                  enter_latch();
               end else begin
                  load_byte();
                  enter_bit_high();
               end
            end
         endcase
      end
      r.line_level = (wave == PH_HIGH);
      r.busy_res   = (wave != PH_IDLE);
      return r;
   endfunction

   // ---------------------------------------------------------------
   // mismatch reporting and response checking
   // ---------------------------------------------------------------
   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   // response side: random stalls, every transfer compared with the oldest owed response
   always @(posedge clock) begin
      line_rsp_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= idle_pct);
         if (rsp_if.valid && rsp_if.ready) begin
            if (line_rsp_fifo.size() == 0) begin
               report_mismatch("response transfer with nothing outstanding");
            end else begin
               want = line_rsp_fifo.pop_front();
               if (rsp_if.line_level !== want.line_level)
                  report_mismatch($sformatf("line_level %b, want %b",
                                            rsp_if.line_level, want.line_level));
               if (rsp_if.busy_res !== want.busy_res)
                  report_mismatch($sformatf("busy_res %b, want %b",
                                            rsp_if.busy_res, want.busy_res));
               if (rsp_if.rejected !== want.rejected)
                  report_mismatch($sformatf("rejected %b, want %b",
                                            rsp_if.rejected, want.rejected));
               if (rsp_if.frame_done !== want.frame_done)
                  report_mismatch($sformatf("frame_done %b, want %b",
                                            rsp_if.frame_done, want.frame_done));
            end
         end
      end
   end

   // watchdog: any transfer on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("** rgb_led_frame_transmitter: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   // sender stops and waits until every owed response has come back
   task automatic drain_pipe();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (line_rsp_fifo.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   // one command transfer; valid stays high so the next command can follow back to back
   task automatic send_led_command(led_cmd_type c, bit typed = 1'b0,
                                   line_rsp_type rsp = RSP_IDLE);
      line_rsp_type r;
      if (csr_open) begin
         csr_if.valid <= 1'b0;
         csr_open = 1'b0;
      end
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cmd   <= c.cmd;
      req_if.col   <= c.col;
      req_if.row   <= c.row;
      req_if.red   <= c.red;
      req_if.green <= c.green;
      req_if.blue  <= c.blue;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      // transfer done at this edge: the shadow moves on even for typed rows
      r = run_led_command(c);
      line_rsp_fifo.push_back(typed ? rsp : r);
      n_sent++;
   endtask

   // register write; the first of a batch waits for the block to go quiet
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      if (!csr_open) drain_pipe();
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         REG_ONE_HIGH:   regs_shadow.one_high_ticks   = val[TICK_W-1:0];
         REG_ONE_LOW:    regs_shadow.one_low_ticks    = val[TICK_W-1:0];
         REG_ZERO_HIGH:  regs_shadow.zero_high_ticks  = val[TICK_W-1:0];
         REG_ZERO_LOW:   regs_shadow.zero_low_ticks   = val[TICK_W-1:0];
         REG_LATCH:      regs_shadow.latch_ticks      = val[LATCH_W-1:0];
         REG_LEDS:       regs_shadow.leds_to_send     = val[LEDS_W-1:0];
         REG_SERPENTINE: regs_shadow.serpentine_order = val[0];
         default: ;
      endcase
      csr_open = 1'b1;
   endtask

   task automatic apply_settings(cfg_type s);
      write_reg(REG_ONE_HIGH,   CSR_DATA_W'(s.one_high_ticks));
      write_reg(REG_ONE_LOW,    CSR_DATA_W'(s.one_low_ticks));
      write_reg(REG_ZERO_HIGH,  CSR_DATA_W'(s.zero_high_ticks));
      write_reg(REG_ZERO_LOW,   CSR_DATA_W'(s.zero_low_ticks));
      write_reg(REG_LATCH,      s.latch_ticks);
      write_reg(REG_LEDS,       CSR_DATA_W'(s.leds_to_send));
      write_reg(REG_SERPENTINE, CSR_DATA_W'(s.serpentine_order));
   endtask

   // random pixel write; any_coord lets coordinates run past the matrix
   function automatic led_cmd_type random_pixel(bit any_coord);
      led_cmd_type c;
      c.cmd   = CMD_PIXEL;
      c.col   = any_coord ? COORD_W'($urandom_range(15))
                          : COORD_W'($urandom_range(MATRIX_WIDTH - 1));
      c.row   = any_coord ? COORD_W'($urandom_range(15))
                          : COORD_W'($urandom_range(MATRIX_HEIGHT - 1));
      c.red   = CHAN_W'($urandom_range(255));
      c.green = CHAN_W'($urandom_range(255));
      c.blue  = CHAN_W'($urandom_range(255));
      return c;
   endfunction

   // well-formed frame: paint some pixels, show, tick until the latch ends
   task automatic play_frame();
      led_cmd_type c;
      int          npix;
      npix = $urandom_range(0, 6);
      if ($urandom_range(9) == 0) begin
         c = random_pixel(1'b1);
         c.cmd = CMD_CLEAR;
         send_led_command(c);
      end
      repeat (npix) send_led_command(random_pixel($urandom_range(9) == 0));
      if ($urandom_range(9) == 0) begin
         c = random_pixel(1'b1);
         c.cmd = cmd_type'($urandom_range(3));
         send_led_command(c);
      end
      c = random_pixel(1'b1);
      c.cmd = CMD_SHOW;
      send_led_command(c);
      while (wave != PH_IDLE) begin
         // now and then hold off until the block has caught up
         if ($urandom_range(299) == 0) drain_pipe();
         c = random_pixel(1'b1);
         // mostly ticks, sometimes a command that must bounce off the busy frame
         c.cmd = ($urandom_range(24) == 0) ? cmd_type'($urandom_range(1, 3)) : CMD_TICK;
         send_led_command(c);
      end
      repeat ($urandom_range(0, 2)) begin
         c = random_pixel(1'b1);
         c.cmd = CMD_TICK;
         send_led_command(c);
      end
   endtask

   function automatic void add_cmd_row(cmd_type cmd, int col, int row, int red, int green,
                                       int blue, bit typed = 1'b0,
                                       line_rsp_type rsp = RSP_IDLE);
      dir_row_type d;
      d.is_csr  = 1'b0;
      d.reg_idx = '0;
      d.reg_val = '0;
      d.item    = '{cmd, col[COORD_W-1:0], row[COORD_W-1:0], red[CHAN_W-1:0],
                    green[CHAN_W-1:0], blue[CHAN_W-1:0]};
      d.typed   = typed;
      d.rsp     = rsp;
      dir_rows.push_back(d);
   endfunction

   function automatic void add_reg_row(logic [CSR_IDX_W-1:0] idx, int val);
      dir_row_type d;
      d.is_csr  = 1'b1;
      d.reg_idx = idx;
      d.reg_val = val[CSR_DATA_W-1:0];
      d.item    = '0;
      d.typed   = 1'b0;
      d.rsp     = RSP_IDLE;
      dir_rows.push_back(d);
   endfunction

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      cfg_type     s;
      led_cmd_type c;
      int          ph;

      // every input known from time zero
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.cmd   = CMD_TICK;
      req_if.col   = '0;
      req_if.row   = '0;
      req_if.red   = '0;
      req_if.green = '0;
      req_if.blue  = '0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data  = '0;
      reset_led_model();

      // directed table, reset timing first
      add_cmd_row(CMD_TICK,   0,  0, 0, 0, 0, 1'b1, RSP_IDLE);         // idle tick
      add_cmd_row(CMD_PIXEL,  0,  0, 8'hff, 8'hff, 8'hff, 1'b1, RSP_IDLE);
      add_cmd_row(CMD_PIXEL,  7,  7, 0, 0, 0, 1'b1, RSP_IDLE);         // far corner
      add_cmd_row(CMD_PIXEL,  8,  3, 8'h12, 8'h34, 8'h56, 1'b1, RSP_REJECT_IDLE);
      add_cmd_row(CMD_PIXEL,  2,  8, 8'h12, 8'h34, 8'h56, 1'b1, RSP_REJECT_IDLE);
      add_cmd_row(CMD_PIXEL, 15, 15, 8'hff, 8'hff, 8'hff, 1'b1, RSP_REJECT_IDLE);
      add_cmd_row(CMD_PIXEL,  7,  1, 8'ha5, 8'h5a, 8'h3c);               // row-major odd row
      add_cmd_row(CMD_CLEAR,  0,  0, 0, 0, 0, 1'b1, RSP_IDLE);
      // zero lengths act as one, no leds, serpentine on
      add_reg_row(REG_ONE_HIGH,   0);
      add_reg_row(REG_ONE_LOW,    1);
      add_reg_row(REG_ZERO_HIGH,  2);
      add_reg_row(REG_ZERO_LOW,   0);
      add_reg_row(REG_LATCH,      3);
      add_reg_row(REG_LEDS,       0);
      add_reg_row(REG_SERPENTINE, 1);
      add_cmd_row(CMD_PIXEL,  0,  1, 8'h81, 8'h42, 8'h24);               // serpentine odd row
      add_cmd_row(CMD_SHOW,   0,  0, 0, 0, 0, 1'b1, RSP_LATCH);        // straight to latch
      add_cmd_row(CMD_PIXEL,  1,  1, 8'hff, 0, 0, 1'b1, RSP_REJECT_BUSY);
      add_cmd_row(CMD_CLEAR,  0,  0, 0, 0, 0, 1'b1, RSP_REJECT_BUSY);
      add_cmd_row(CMD_SHOW,   0,  0, 0, 0, 0, 1'b1, RSP_REJECT_BUSY);
      add_cmd_row(CMD_TICK,   0,  0, 0, 0, 0);
      add_cmd_row(CMD_TICK,   0,  0, 0, 0, 0);
      add_cmd_row(CMD_TICK,   0,  0, 0, 0, 0, 1'b1, RSP_DONE);         // latch ends
      add_cmd_row(CMD_TICK,   0,  0, 0, 0, 0, 1'b1, RSP_IDLE);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_csr)
            write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
         else
            send_led_command(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].rsp);
      end

      // random phases with short pulses and few leds; the first runs without idling
      ph = 0;
      while (n_sent < RANDOM_ITEMS) begin
         s.one_high_ticks   = TICK_W'($urandom_range(1, 4));
         s.one_low_ticks    = TICK_W'($urandom_range(1, 4));
         s.zero_high_ticks  = TICK_W'($urandom_range(1, 4));
         s.zero_low_ticks   = TICK_W'($urandom_range(1, 4));
         s.latch_ticks      = LATCH_W'($urandom_range(1, 12));
         s.leds_to_send     = ($urandom_range(4) == 0) ? '0 : LEDS_W'($urandom_range(1, 5));
         s.serpentine_order = 1'($urandom_range(1));
         apply_settings(s);
         idle_pct = (ph == 0) ? 0 : BASE_IDLE_PCT;
         repeat ($urandom_range(1, 3)) play_frame();
         ph++;
      end
      idle_pct = BASE_IDLE_PCT;

      // widest pulses on the single one bit of one led, zero bits as short as possible
      s = '{8'd255, 8'd255, 8'd1, 8'd1, 13'd40, 7'd1, 1'b0};
      apply_settings(s);
      c = '{CMD_CLEAR, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0};
      send_led_command(c);
      c = '{CMD_PIXEL, 4'd0, 4'd0, 8'd0, 8'h80, 8'd0};
      send_led_command(c);
      c.cmd = CMD_SHOW;
      send_led_command(c);
      c.cmd = CMD_TICK;
      while (wave != PH_IDLE) send_led_command(c);
      send_led_command(c);

      req_if.valid <= 1'b0;
      while (line_rsp_fifo.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("** rgb_led_frame_transmitter: PASSED **");
      else
         $display("** rgb_led_frame_transmitter: FAILED **");
      $finish;
   end

endmodule
